// ===== rtl/core/dtrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtrc_pkg: shared types and constants of the terminal request tracker
// Field widths, command and register codes, and the words passed between the
// front end, the queue and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dtrc_pkg;

    localparam int RATE_BITS      = 16;
    localparam int TIMER_BITS     = 8;
    localparam int CREDIT_BITS    = 20;
    localparam int VOL_BITS       = 16;
    localparam int FPS_BITS       = 8;
    localparam int CMD_BITS       = 3;
    localparam int AMOUNT_BITS    = 16;
    localparam int TOTAL_BITS     = 18;
    localparam int TAKE_BITS      = AMOUNT_BITS + FPS_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // Command codes carried in the command field.
    localparam logic [CMD_BITS-1:0] CMD_RBDC_REQ   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD_CREDIT = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_RBDC_ALLOC = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_VBDC_REQ   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_VBDC_ALLOC = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_FCA_ALLOC  = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_FRAME_TICK = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_READ       = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_CRA_RATE        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RBDC_RATE   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RBDC_TIMEOUT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VBDC_VOLUME = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAMES_PER_SF   = 3'd4;

    typedef struct packed {
        logic [RATE_BITS-1:0]  cra_rate;
        logic [RATE_BITS-1:0]  max_rbdc_rate;
        logic [TIMER_BITS-1:0] rbdc_timeout;
        logic [VOL_BITS-1:0]   max_vbdc_volume;
        logic [FPS_BITS-1:0]   frames_per_superframe;
    } cfg_t;

    // Decoded operation: at most one flag is set, none for a read.
    typedef struct packed {
        logic rbdc_req;
        logic add_credit;
        logic rbdc_alloc;
        logic vbdc_req;
        logic vbdc_alloc;
        logic fca_alloc;
        logic frame_tick;
    } op_flags_t;

    typedef struct packed {
        op_flags_t              op;
        logic [AMOUNT_BITS-1:0] amount;
    } cmd_item_t;

    typedef struct packed {
        logic [RATE_BITS-1:0]   rbdc_request_now;
        logic [CREDIT_BITS-1:0] rbdc_credit_now;
        logic [TIMER_BITS-1:0]  rbdc_timer_now;
        logic [TOTAL_BITS-1:0]  total_rate_alloc;
        logic [VOL_BITS-1:0]    vbdc_request_now;
        logic [VOL_BITS-1:0]    vbdc_per_frame;
        logic [VOL_BITS-1:0]    vbdc_alloc_total;
    } status_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/dtrc_in_if.sv =====
// ----------------------------------------------------------------------------
// dtrc_in_if: event channel
// Valid/ready channel carrying one command and its amount per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtrc_in_if;
    logic                               valid;
    logic                               ready;
    logic [dtrc_pkg::CMD_BITS-1:0]      command;
    logic [dtrc_pkg::AMOUNT_BITS-1:0]   amount;

    modport source (output valid, output command, output amount, input ready);
    modport sink   (input valid, input command, input amount, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dtrc_out_if.sv =====
// ----------------------------------------------------------------------------
// dtrc_out_if: status channel
// Valid/ready channel carrying one status report per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtrc_out_if;
    logic                               valid;
    logic                               ready;
    logic [dtrc_pkg::RATE_BITS-1:0]     rbdc_request_now;
    logic [dtrc_pkg::CREDIT_BITS-1:0]   rbdc_credit_now;
    logic [dtrc_pkg::TIMER_BITS-1:0]    rbdc_timer_now;
    logic [dtrc_pkg::TOTAL_BITS-1:0]    total_rate_alloc;
    logic [dtrc_pkg::VOL_BITS-1:0]      vbdc_request_now;
    logic [dtrc_pkg::VOL_BITS-1:0]      vbdc_per_frame;
    logic [dtrc_pkg::VOL_BITS-1:0]      vbdc_alloc_total;

    modport source (
        output valid, output rbdc_request_now, output rbdc_credit_now,
        output rbdc_timer_now, output total_rate_alloc, output vbdc_request_now,
        output vbdc_per_frame, output vbdc_alloc_total, input ready
    );
    modport sink (
        input valid, input rbdc_request_now, input rbdc_credit_now,
        input rbdc_timer_now, input total_rate_alloc, input vbdc_request_now,
        input vbdc_per_frame, input vbdc_alloc_total, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/dama_terminal_request_context.sv =====
// ----------------------------------------------------------------------------
// dama_terminal_request_context: per-terminal DAMA request tracker
// Keeps the RBDC, VBDC, FCA and CRA bookkeeping of one terminal and reports
// the resulting request status after every event.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the events channel carries one command and an amount. Every
// accepted word produces exactly one status word on the status channel, in
// order, showing the terminal state after that command.
// The front end decodes a word, registers it and hands it to a two-entry
// queue. The back end then scales a VBDC grant by the frames per superframe,
// updates the state and runs two byte-wide division steps for the rounded-up
// per-frame VBDC figure, then loads the output register. It takes the next
// word from the queue only as it finishes the current one. When the status
// receiver stalls, the finished word waits in the output register while the
// back end, the queue and the front end keep taking up to four more words.
// Reset clears all terminal state and sets frames per superframe to one and
// the other configuration registers to zero. The user must write the
// configuration port only while no word is in flight; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module dama_terminal_request_context (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [dtrc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [dtrc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    dtrc_in_if.sink                                    events,
    dtrc_out_if.source                                 status
);

    // Configuration registers, written one at a time by index.
    dtrc_pkg::cfg_t       cfg_reg;
    dtrc_pkg::cfg_t       cfg_next;

    // Decoded words travelling from the front end into the queue.
    dtrc_pkg::cmd_item_t  push_item;
    logic                 push_valid;
    logic                 push_ready;

    // Words leaving the queue toward the back end.
    dtrc_pkg::cmd_item_t  pop_item;
    logic                 pop_valid;
    logic                 pop_ready;

    // A write to an index beyond the register list leaves everything as is.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dtrc_pkg::REG_CRA_RATE:
                    cfg_next.cra_rate = cfg_data[dtrc_pkg::RATE_BITS-1:0];
                dtrc_pkg::REG_MAX_RBDC_RATE:
                    cfg_next.max_rbdc_rate = cfg_data[dtrc_pkg::RATE_BITS-1:0];
                dtrc_pkg::REG_RBDC_TIMEOUT:
                    cfg_next.rbdc_timeout = cfg_data[dtrc_pkg::TIMER_BITS-1:0];
                dtrc_pkg::REG_MAX_VBDC_VOLUME:
                    cfg_next.max_vbdc_volume = cfg_data[dtrc_pkg::VOL_BITS-1:0];
                dtrc_pkg::REG_FRAMES_PER_SF:
                    cfg_next.frames_per_superframe = cfg_data[dtrc_pkg::FPS_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cra_rate              <= '0;
            cfg_reg.max_rbdc_rate         <= '0;
            cfg_reg.rbdc_timeout          <= '0;
            cfg_reg.max_vbdc_volume       <= '0;
            cfg_reg.frames_per_superframe <= dtrc_pkg::FPS_BITS'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: takes event words and decodes the command.
    dtrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .events     (events),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Queue that decouples intake from execution.
    dtrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Back end: applies the command and builds the status word.
    dtrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dtrc_front.sv =====
// ----------------------------------------------------------------------------
// dtrc_front: event intake and decode
// Accepts event words, decodes the command into operation flags and holds the
// decoded word in one register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtrc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    dtrc_in_if.sink                  events,
    output dtrc_pkg::cmd_item_t      push_item,
    output logic                     push_valid,
    input  wire logic                push_ready
);

    logic                 valid_reg;
    logic                 valid_next;
    dtrc_pkg::cmd_item_t  item_reg;
    dtrc_pkg::op_flags_t  op_dec;
    logic                 accept;

    always_comb
    begin
        op_dec = '0;
        unique case (events.command)
            dtrc_pkg::CMD_RBDC_REQ:   op_dec.rbdc_req   = 1'b1;
            dtrc_pkg::CMD_ADD_CREDIT: op_dec.add_credit = 1'b1;
            dtrc_pkg::CMD_RBDC_ALLOC: op_dec.rbdc_alloc = 1'b1;
            dtrc_pkg::CMD_VBDC_REQ:   op_dec.vbdc_req   = 1'b1;
            dtrc_pkg::CMD_VBDC_ALLOC: op_dec.vbdc_alloc = 1'b1;
            dtrc_pkg::CMD_FCA_ALLOC:  op_dec.fca_alloc  = 1'b1;
            dtrc_pkg::CMD_FRAME_TICK: op_dec.frame_tick = 1'b1;
            dtrc_pkg::CMD_READ:       op_dec = '0;
            default:                  op_dec = '0;
        endcase
    end

    assign events.ready = !valid_reg || push_ready;
    assign accept       = events.valid && events.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op     <= op_dec;
            item_reg.amount <= events.amount;
        end
    end

    assign push_item  = item_reg;
    assign push_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dtrc_queue.sv =====
// ----------------------------------------------------------------------------
// dtrc_queue: decoded command queue
// Small FIFO between the front end and the back end so each side can stall
// on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module dtrc_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  dtrc_pkg::cmd_item_t      push_item,
    input  wire logic                push_valid,
    output logic                     push_ready,
    output dtrc_pkg::cmd_item_t      pop_item,
    output logic                     pop_valid,
    input  wire logic                pop_ready
);

    dtrc_pkg::cmd_item_t                entries_reg [dtrc_pkg::QUEUE_DEPTH];
    logic [dtrc_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [dtrc_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [dtrc_pkg::QCNT_BITS-1:0]     count_reg;
    logic [dtrc_pkg::QCNT_BITS-1:0]     count_next;
    logic                               push_fire;
    logic                               pop_fire;

    assign push_ready = count_reg != dtrc_pkg::QCNT_BITS'(dtrc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
                wr_ptr_reg <= (wr_ptr_reg == dtrc_pkg::QPTR_BITS'(dtrc_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= (rd_ptr_reg == dtrc_pkg::QPTR_BITS'(dtrc_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== rtl/core/dtrc_back.sv =====
// ----------------------------------------------------------------------------
// dtrc_back: request state execution
// Pops decoded commands, scales VBDC grants, updates the terminal state,
// divides the VBDC request over the superframe and loads the status register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtrc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  dtrc_pkg::cfg_t           cfg,
    input  dtrc_pkg::cmd_item_t      pop_item,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    dtrc_out_if.source               status
);

    localparam int STATE_BITS = 3;
    localparam logic [STATE_BITS-1:0] ST_IDLE   = 3'd0;
    localparam logic [STATE_BITS-1:0] ST_MUL    = 3'd1;
    localparam logic [STATE_BITS-1:0] ST_EXEC   = 3'd2;
    localparam logic [STATE_BITS-1:0] ST_DIV_HI = 3'd3;
    localparam logic [STATE_BITS-1:0] ST_DIV_LO = 3'd4;
    localparam logic [STATE_BITS-1:0] ST_HOLD   = 3'd5;

    localparam int RATE_W   = dtrc_pkg::RATE_BITS;
    localparam int CREDIT_W = dtrc_pkg::CREDIT_BITS;
    localparam int TIMER_W  = dtrc_pkg::TIMER_BITS;
    localparam int VOL_W    = dtrc_pkg::VOL_BITS;
    localparam int FPS_W    = dtrc_pkg::FPS_BITS;
    localparam int TAKE_W   = dtrc_pkg::TAKE_BITS;
    localparam int HALF_W   = VOL_W / 2;

    // One byte of restoring division: returns {remainder, quotient byte}.
    function automatic logic [2*HALF_W-1:0] div_step(
        input logic [FPS_W-1:0]  rem_in,
        input logic [HALF_W-1:0] bits_in,
        input logic [FPS_W-1:0]  divisor
    );
        logic [FPS_W:0]      r;
        logic [FPS_W-1:0]    rem;
        logic [HALF_W-1:0]   q;
        rem = rem_in;
        q   = '0;
        for (int i = HALF_W - 1; i >= 0; i--)
        begin
            r = {rem, bits_in[i]};
            if (r >= {1'b0, divisor})
            begin
                r    = r - {1'b0, divisor};
                q[i] = 1'b1;
            end
            rem = r[FPS_W-1:0];
        end
        return {rem, q};
    endfunction

    logic [STATE_BITS-1:0]  state_reg;
    logic [STATE_BITS-1:0]  state_next;

    logic [RATE_W-1:0]      rbdc_request_reg, rbdc_request_next;
    logic [CREDIT_W-1:0]    rbdc_credit_reg,  rbdc_credit_next;
    logic [TIMER_W-1:0]     rbdc_timer_reg,   rbdc_timer_next;
    logic [RATE_W-1:0]      rbdc_alloc_reg,   rbdc_alloc_next;
    logic [RATE_W-1:0]      fca_alloc_reg,    fca_alloc_next;
    logic [VOL_W-1:0]       vbdc_request_reg, vbdc_request_next;
    logic [VOL_W-1:0]       vbdc_alloc_reg,   vbdc_alloc_next;

    dtrc_pkg::cmd_item_t    item_reg;
    logic [TAKE_W-1:0]      take_reg;
    logic [VOL_W-1:0]       quot_reg;
    logic [FPS_W-1:0]       rem_reg;

    logic                   out_valid_reg;
    dtrc_pkg::status_word_t out_word_reg;
    dtrc_pkg::status_word_t out_word;

    logic [FPS_W-1:0]       fps_eff;
    logic                   out_free;
    logic                   finish_now;
    logic                   pop_fire;
    logic [2*HALF_W-1:0]    step_hi;
    logic [2*HALF_W-1:0]    step_lo;
    logic [VOL_W-1:0]       fin_quot;
    logic [FPS_W-1:0]       fin_rem;
    logic [VOL_W:0]         per_frame_sum;

    logic [CREDIT_W:0]      credit_sum;
    logic [VOL_W:0]         vreq_sum;
    logic [VOL_W:0]         valloc_sum;
    logic [TIMER_W-1:0]     timer_dec;
    logic [RATE_W-1:0]      clamped_req;

    assign fps_eff    = (cfg.frames_per_superframe == '0) ? FPS_W'(1)
                                                          : cfg.frames_per_superframe;
    assign out_free   = !out_valid_reg || status.ready;
    assign finish_now = ((state_reg == ST_DIV_LO) || (state_reg == ST_HOLD)) && out_free;
    assign pop_ready  = (state_reg == ST_IDLE) || finish_now;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE:   if (pop_fire) state_next = ST_MUL;
            ST_MUL:    state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_DIV_HI;
            ST_DIV_HI: state_next = ST_DIV_LO;
            ST_DIV_LO, ST_HOLD:
            begin
                if (!out_free)
                    state_next = ST_HOLD;
                else if (pop_fire)
                    state_next = ST_MUL;
                else
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // State update for the command held in item_reg.
    always_comb
    begin
        rbdc_request_next = rbdc_request_reg;
        rbdc_credit_next  = rbdc_credit_reg;
        rbdc_timer_next   = rbdc_timer_reg;
        rbdc_alloc_next   = rbdc_alloc_reg;
        fca_alloc_next    = fca_alloc_reg;
        vbdc_request_next = vbdc_request_reg;
        vbdc_alloc_next   = vbdc_alloc_reg;

        clamped_req = (item_reg.amount < cfg.max_rbdc_rate) ? item_reg.amount
                                                            : cfg.max_rbdc_rate;
        credit_sum  = {1'b0, rbdc_credit_reg} + (CREDIT_W + 1)'(item_reg.amount);
        vreq_sum    = {1'b0, vbdc_request_reg} + {1'b0, item_reg.amount};
        valloc_sum  = {1'b0, vbdc_alloc_reg} + {1'b0, item_reg.amount};
        timer_dec   = (rbdc_timer_reg != '0) ? rbdc_timer_reg - 1'b1 : '0;

        if (state_reg == ST_EXEC)
        begin
            if (item_reg.op.rbdc_req)
            begin
                rbdc_request_next = clamped_req;
                rbdc_credit_next  = '0;
                rbdc_timer_next   = cfg.rbdc_timeout;
            end
            if (item_reg.op.add_credit)
                rbdc_credit_next = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
            if (item_reg.op.rbdc_alloc)
                rbdc_alloc_next = item_reg.amount;
            if (item_reg.op.fca_alloc)
                fca_alloc_next = item_reg.amount;
            if (item_reg.op.vbdc_req)
                vbdc_request_next = (vreq_sum > {1'b0, cfg.max_vbdc_volume})
                                    ? cfg.max_vbdc_volume : vreq_sum[VOL_W-1:0];
            if (item_reg.op.vbdc_alloc)
            begin
                vbdc_alloc_next   = valloc_sum[VOL_W] ? '1 : valloc_sum[VOL_W-1:0];
                vbdc_request_next = (TAKE_W'(vbdc_request_reg) >= take_reg)
                                    ? vbdc_request_reg - take_reg[VOL_W-1:0] : '0;
            end
            if (item_reg.op.frame_tick)
            begin
                rbdc_timer_next = timer_dec;
                if (timer_dec != '0)
                begin
                    if (rbdc_credit_reg != '0)
                    begin
                        rbdc_credit_next  = rbdc_credit_reg - 1'b1;
                        rbdc_request_next = (rbdc_request_reg == '1)
                                            ? rbdc_request_reg : rbdc_request_reg + 1'b1;
                    end
                end
                else
                begin
                    rbdc_request_next = '0;
                    rbdc_credit_next  = '0;
                end
                rbdc_alloc_next = '0;
                fca_alloc_next  = '0;
                vbdc_alloc_next = '0;
            end
        end
    end

    // Two byte-wide division steps give floor and remainder of the request.
    assign step_hi  = div_step('0, vbdc_request_reg[VOL_W-1:HALF_W], fps_eff);
    assign step_lo  = div_step(rem_reg, vbdc_request_reg[HALF_W-1:0], fps_eff);
    assign fin_quot = (state_reg == ST_DIV_LO) ? {quot_reg[VOL_W-1:HALF_W],
                                                  step_lo[HALF_W-1:0]} : quot_reg;
    assign fin_rem  = (state_reg == ST_DIV_LO) ? step_lo[2*HALF_W-1:HALF_W] : rem_reg;
    assign per_frame_sum = {1'b0, fin_quot} + (VOL_W + 1)'(fin_rem != '0);

    always_comb
    begin
        out_word.rbdc_request_now = rbdc_request_reg;
        out_word.rbdc_credit_now  = rbdc_credit_reg;
        out_word.rbdc_timer_now   = rbdc_timer_reg;
        out_word.total_rate_alloc = dtrc_pkg::TOTAL_BITS'(rbdc_alloc_reg)
                                  + dtrc_pkg::TOTAL_BITS'(fca_alloc_reg)
                                  + dtrc_pkg::TOTAL_BITS'(cfg.cra_rate);
        out_word.vbdc_request_now = vbdc_request_reg;
        out_word.vbdc_per_frame   = per_frame_sum[VOL_W-1:0];
        out_word.vbdc_alloc_total = vbdc_alloc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rbdc_request_reg <= '0;
            rbdc_credit_reg  <= '0;
            rbdc_timer_reg   <= '0;
            rbdc_alloc_reg   <= '0;
            fca_alloc_reg    <= '0;
            vbdc_request_reg <= '0;
            vbdc_alloc_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rbdc_request_reg <= rbdc_request_next;
            rbdc_credit_reg  <= rbdc_credit_next;
            rbdc_timer_reg   <= rbdc_timer_next;
            rbdc_alloc_reg   <= rbdc_alloc_next;
            fca_alloc_reg    <= fca_alloc_next;
            vbdc_request_reg <= vbdc_request_next;
            vbdc_alloc_reg   <= vbdc_alloc_next;
            if (finish_now)
                out_valid_reg <= 1'b1;
            else if (status.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
            item_reg <= pop_item;
        if (state_reg == ST_MUL)
            take_reg <= TAKE_W'(item_reg.amount) * TAKE_W'(fps_eff);
        if (state_reg == ST_DIV_HI)
        begin
            quot_reg[VOL_W-1:HALF_W] <= step_hi[HALF_W-1:0];
            rem_reg                  <= step_hi[2*HALF_W-1:HALF_W];
        end
        if (state_reg == ST_DIV_LO)
        begin
            quot_reg[HALF_W-1:0] <= step_lo[HALF_W-1:0];
            rem_reg              <= step_lo[2*HALF_W-1:HALF_W];
        end
        if (finish_now)
            out_word_reg <= out_word;
    end

    assign status.valid            = out_valid_reg;
    assign status.rbdc_request_now = out_word_reg.rbdc_request_now;
    assign status.rbdc_credit_now  = out_word_reg.rbdc_credit_now;
    assign status.rbdc_timer_now   = out_word_reg.rbdc_timer_now;
    assign status.total_rate_alloc = out_word_reg.total_rate_alloc;
    assign status.vbdc_request_now = out_word_reg.vbdc_request_now;
    assign status.vbdc_per_frame   = out_word_reg.vbdc_per_frame;
    assign status.vbdc_alloc_total = out_word_reg.vbdc_alloc_total;

endmodule

`default_nettype wire

// ===== dv/dtrc_status_checker.sv =====
// ----------------------------------------------------------------------------
// dtrc_status_checker: status word predictor and comparator
// Watches the event, status and configuration traffic of the terminal
// request tracker. It keeps its own copy of the terminal state, works out
// the status word that each accepted event must produce, and compares each
// delivered status word, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module dtrc_status_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [dtrc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [dtrc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    dtrc_in_if                                        events,
    dtrc_out_if                                       status,
    output int                                        mismatches,
    output int                                        status_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dtrc_pkg::*;

    // Configuration copy.
    logic [RATE_BITS-1:0]  cra_rate;
    logic [RATE_BITS-1:0]  max_rbdc_rate;
    logic [TIMER_BITS-1:0] rbdc_timeout;
    logic [VOL_BITS-1:0]   max_vbdc_volume;
    logic [FPS_BITS-1:0]   frames_per_sf;

    // Terminal state copy.
    logic [RATE_BITS-1:0]   rbdc_request;
    logic [CREDIT_BITS-1:0] rbdc_credit;
    logic [TIMER_BITS-1:0]  rbdc_timer;
    logic [RATE_BITS-1:0]   rbdc_alloc;
    logic [RATE_BITS-1:0]   fca_alloc;
    logic [VOL_BITS-1:0]    vbdc_request;
    logic [VOL_BITS-1:0]    vbdc_alloc;

    status_word_t status_due[$];

    // Applies one event to the terminal state and returns the status word
    // that the block must report afterwards.
    function automatic status_word_t advance_terminal(
        input logic [CMD_BITS-1:0]    cmd,
        input logic [AMOUNT_BITS-1:0] amt
    );
        logic [FPS_BITS-1:0]    fps;
        logic [TAKE_BITS-1:0]   take;
        logic [CREDIT_BITS:0]   credit_sum;
        logic [VOL_BITS:0]      vol_sum;
        logic [TAKE_BITS-1:0]   per_frame;
        status_word_t           word;
        fps = (frames_per_sf == '0) ? FPS_BITS'(1) : frames_per_sf;
        case (cmd)
            CMD_RBDC_REQ:
            begin
                rbdc_request = (amt < max_rbdc_rate) ? amt : max_rbdc_rate;
                rbdc_credit  = '0;
                rbdc_timer   = rbdc_timeout;
            end
            CMD_ADD_CREDIT:
            begin
                credit_sum  = (CREDIT_BITS+1)'(rbdc_credit) + (CREDIT_BITS+1)'(amt);
                rbdc_credit = credit_sum[CREDIT_BITS] ? '1 : credit_sum[CREDIT_BITS-1:0];
            end
            CMD_RBDC_ALLOC:
            begin
                rbdc_alloc = amt;
            end
            CMD_VBDC_REQ:
            begin
                vol_sum      = (VOL_BITS+1)'(vbdc_request) + (VOL_BITS+1)'(amt);
                vbdc_request = (vol_sum > (VOL_BITS+1)'(max_vbdc_volume))
                               ? max_vbdc_volume : vol_sum[VOL_BITS-1:0];
            end
            CMD_VBDC_ALLOC:
            begin
                take       = TAKE_BITS'(amt) * TAKE_BITS'(fps);
                vol_sum    = (VOL_BITS+1)'(vbdc_alloc) + (VOL_BITS+1)'(amt);
                vbdc_alloc = vol_sum[VOL_BITS] ? '1 : vol_sum[VOL_BITS-1:0];
                if (TAKE_BITS'(vbdc_request) >= take)
                begin
                    vbdc_request = vbdc_request - take[VOL_BITS-1:0];
                end
                else
                begin
                    vbdc_request = '0;
                end
            end
            CMD_FCA_ALLOC:
            begin
                fca_alloc = amt;
            end
            CMD_FRAME_TICK:
            begin
                if (rbdc_timer != '0)
                begin
                    rbdc_timer = rbdc_timer - 1'b1;
                end
                if (rbdc_timer != '0)
                begin
                    if (rbdc_credit != '0)
                    begin
                        rbdc_credit = rbdc_credit - 1'b1;
                        if (rbdc_request != '1)
                        begin
                            rbdc_request = rbdc_request + 1'b1;
                        end
                    end
                end
                else
                begin
                    rbdc_request = '0;
                    rbdc_credit  = '0;
                end
                rbdc_alloc = '0;
                fca_alloc  = '0;
                vbdc_alloc = '0;
            end
            default:
            begin
            end
        endcase
        per_frame = (TAKE_BITS'(vbdc_request) + TAKE_BITS'(fps) - TAKE_BITS'(1))
                    / TAKE_BITS'(fps);
        word.rbdc_request_now = rbdc_request;
        word.rbdc_credit_now  = rbdc_credit;
        word.rbdc_timer_now   = rbdc_timer;
        word.total_rate_alloc = TOTAL_BITS'(rbdc_alloc) + TOTAL_BITS'(fca_alloc)
                                + TOTAL_BITS'(cra_rate);
        word.vbdc_request_now = vbdc_request;
        word.vbdc_per_frame   = per_frame[VOL_BITS-1:0];
        word.vbdc_alloc_total = vbdc_alloc;
        return word;
    endfunction

    function automatic int field_differs(
        input string       name,
        input logic [31:0] want_v,
        input logic [31:0] got_v
    );
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        status_word_t got;
        status_word_t want;
        if (!rst_n)
        begin
            cra_rate        = '0;
            max_rbdc_rate   = '0;
            rbdc_timeout    = '0;
            max_vbdc_volume = '0;
            frames_per_sf   = FPS_BITS'(1);
            rbdc_request    = '0;
            rbdc_credit     = '0;
            rbdc_timer      = '0;
            rbdc_alloc      = '0;
            fca_alloc       = '0;
            vbdc_request    = '0;
            vbdc_alloc      = '0;
            status_due.delete();
            mismatches      = 0;
            status_pending  = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CRA_RATE:        cra_rate        = cfg_data[RATE_BITS-1:0];
                    REG_MAX_RBDC_RATE:   max_rbdc_rate   = cfg_data[RATE_BITS-1:0];
                    REG_RBDC_TIMEOUT:    rbdc_timeout    = cfg_data[TIMER_BITS-1:0];
                    REG_MAX_VBDC_VOLUME: max_vbdc_volume = cfg_data[VOL_BITS-1:0];
                    REG_FRAMES_PER_SF:   frames_per_sf   = cfg_data[FPS_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (status.valid && status.ready)
            begin
                got.rbdc_request_now = status.rbdc_request_now;
                got.rbdc_credit_now  = status.rbdc_credit_now;
                got.rbdc_timer_now   = status.rbdc_timer_now;
                got.total_rate_alloc = status.total_rate_alloc;
                got.vbdc_request_now = status.vbdc_request_now;
                got.vbdc_per_frame   = status.vbdc_per_frame;
                got.vbdc_alloc_total = status.vbdc_alloc_total;
                if (status_due.size() == 0)
                begin
                    $error("status word delivered with no event outstanding");
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = status_due.pop_front();
                    mismatches = mismatches
                        + field_differs("rbdc_request_now", 32'(want.rbdc_request_now),
                                        32'(got.rbdc_request_now))
                        + field_differs("rbdc_credit_now", 32'(want.rbdc_credit_now),
                                        32'(got.rbdc_credit_now))
                        + field_differs("rbdc_timer_now", 32'(want.rbdc_timer_now),
                                        32'(got.rbdc_timer_now))
                        + field_differs("total_rate_alloc", 32'(want.total_rate_alloc),
                                        32'(got.total_rate_alloc))
                        + field_differs("vbdc_request_now", 32'(want.vbdc_request_now),
                                        32'(got.vbdc_request_now))
                        + field_differs("vbdc_per_frame", 32'(want.vbdc_per_frame),
                                        32'(got.vbdc_per_frame))
                        + field_differs("vbdc_alloc_total", 32'(want.vbdc_alloc_total),
                                        32'(got.vbdc_alloc_total));
                end
            end
            if (events.valid && events.ready)
            begin
                status_due.push_back(advance_terminal(events.command, events.amount));
            end
            status_pending = status_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the terminal request tracker
// Drives event words with random gaps, stalls the status channel in random
// bursts and twice for a long stretch, and steps the configuration through
// reset values, both extremes and random settings. A separate checker
// predicts every status word and reports mismatches; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtrc_pkg::*;

    // The slowest correct run stays far below this: about 1750 words, each
    // at worst with a random gap, its trip through the block and a random
    // status stall, plus the two long holds and the configuration pauses.
    localparam int CYCLE_LIMIT   = 500000;
    // Length of the long status hold; far more than the block can buffer.
    localparam int LONG_HOLD     = 200;
    // Words per random phase; six phases plus the directed words make about
    // 1750 words in total.
    localparam int PHASE_WORDS   = 290;
    localparam int RANDOM_PHASES = 6;
    // Quiet cycles after the last status word.
    localparam int DRAIN_CYCLES  = 24;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    dtrc_in_if  ev_if ();
    dtrc_out_if st_if ();

    int mismatches;
    int status_pending;

    // Shared between the event driver and the status receiver. Only the
    // event driver writes these.
    bit idle_on;
    bit hold_wanted;
    int phase_no;

    int words_sent;
    int cycle_count;

    dama_terminal_request_context dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .events    (ev_if),
        .status    (st_if)
    );

    dtrc_status_checker u_status_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .events         (ev_if),
        .status         (st_if),
        .mismatches     (mismatches),
        .status_pending (status_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A run that hangs ends here with a failure.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Status receiver. Ready changes only at the falling edge, once per
    // cycle. It stalls in random bursts while idling is on, and once per
    // requested phase it holds off for a long stretch so that the block's
    // queue fills up and the event channel backs up behind it.
    initial
    begin : status_sink
        int stall_left;
        int held_phase;
        stall_left = 0;
        held_phase = -1;
        st_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                st_if.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (hold_wanted && phase_no != held_phase)
            begin
                held_phase = phase_no;
                stall_left = LONG_HOLD - 1;
                st_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                st_if.ready <= 1'b0;
            end
            else
            begin
                st_if.ready <= 1'b1;
            end
        end
    end

    // Amounts lean on the edges: zero, all ones and small values show up
    // far more often than a flat draw would give them.
    function automatic logic [AMOUNT_BITS-1:0] pick_amount();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return AMOUNT_BITS'($urandom_range(1, 16));
            default: return AMOUNT_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offers one event word from a falling edge and returns at the falling
    // edge after it was taken. Valid stays high across back-to-back words.
    task automatic send_word(
        input logic [CMD_BITS-1:0]    cmd,
        input logic [AMOUNT_BITS-1:0] amt
    );
        ev_if.valid   <= 1'b1;
        ev_if.command <= cmd;
        ev_if.amount  <= amt;
        @(posedge clk);
        while (ev_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        words_sent = words_sent + 1;
    endtask

    // Sends a word, sometimes after a random gap with valid low.
    task automatic post_event(
        input logic [CMD_BITS-1:0]    cmd,
        input logic [AMOUNT_BITS-1:0] amt
    );
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            ev_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        send_word(cmd, amt);
    endtask

    // Every word yields exactly one status word, so once none is due the
    // block holds no work and the configuration may change.
    task automatic wait_drained();
        ev_if.valid <= 1'b0;
        while (status_pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_BITS-1:0] idx,
        input logic [CFG_DATA_BITS-1:0]  value
    );
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic program_regs(
        input logic [CFG_DATA_BITS-1:0] cra,
        input logic [CFG_DATA_BITS-1:0] max_rate,
        input logic [CFG_DATA_BITS-1:0] timeout,
        input logic [CFG_DATA_BITS-1:0] max_volume,
        input logic [CFG_DATA_BITS-1:0] fps
    );
        write_reg(REG_CRA_RATE, cra);
        write_reg(REG_MAX_RBDC_RATE, max_rate);
        write_reg(REG_RBDC_TIMEOUT, timeout);
        write_reg(REG_MAX_VBDC_VOLUME, max_volume);
        write_reg(REG_FRAMES_PER_SF, fps);
        cfg_wr_en <= 1'b0;
    endtask

    // Random traffic built mostly from realistic signaling sessions so the
    // timer, credit and VBDC paths get exercised in depth, mixed with
    // single words of any command as noise.
    task automatic run_sessions(input int count, input bit may_idle);
        int first;
        int reps;
        int i;
        first = words_sent;
        while (words_sent - first < count)
        begin
            // Idling comes and goes in stretches.
            if (may_idle && $urandom_range(0, 9) == 0)
            begin
                idle_on = ~idle_on;
            end
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    post_event(CMD_BITS'($urandom_range(0, 7)), pick_amount());
                end
                2, 3, 4:
                begin
                    // Rate request, a few credit top-ups and a rate grant, then
                    // frames pass until the request ages out or the session is cut short.
                    post_event(CMD_RBDC_REQ, pick_amount());
                    reps = $urandom_range(0, 4);
                    for (i = 0; i < reps; i++)
                    begin
                        post_event(CMD_ADD_CREDIT,
                                   ($urandom_range(0, 1) == 0)
                                   ? AMOUNT_BITS'($urandom_range(0, 8)) : pick_amount());
                    end
                    post_event(CMD_RBDC_ALLOC, pick_amount());
                    reps = $urandom_range(1, 8);
                    for (i = 0; i < reps; i++)
                    begin
                        post_event(CMD_FRAME_TICK, pick_amount());
                        if ($urandom_range(0, 3) == 0)
                        begin
                            post_event(CMD_READ, pick_amount());
                        end
                    end
                end
                5, 6, 7:
                begin
                    // Volume requests, then grants that get scaled by the
                    // superframe length; grants are mostly small so the
                    // request does not always collapse to zero.
                    reps = $urandom_range(1, 4);
                    for (i = 0; i < reps; i++)
                    begin
                        post_event(CMD_VBDC_REQ, pick_amount());
                    end
                    reps = $urandom_range(1, 3);
                    for (i = 0; i < reps; i++)
                    begin
                        post_event(CMD_VBDC_ALLOC,
                                   ($urandom_range(0, 3) == 0)
                                   ? pick_amount() : AMOUNT_BITS'($urandom_range(0, 200)));
                    end
                    if ($urandom_range(0, 1) == 0)
                    begin
                        post_event(CMD_FRAME_TICK, pick_amount());
                    end
                end
                8:
                begin
                    // Credit flood: enough full-size top-ups to reach the
                    // credit ceiling before any frame tick.
                    post_event(CMD_RBDC_REQ, pick_amount());
                    reps = $urandom_range(17, 20);
                    for (i = 0; i < reps; i++)
                    begin
                        post_event(CMD_ADD_CREDIT,
                                   ($urandom_range(0, 3) == 0) ? pick_amount() : '1);
                    end
                    reps = $urandom_range(1, 3);
                    for (i = 0; i < reps; i++)
                    begin
                        post_event(CMD_FRAME_TICK, pick_amount());
                    end
                end
                default:
                begin
                    post_event(CMD_RBDC_ALLOC, pick_amount());
                    post_event(CMD_FCA_ALLOC, pick_amount());
                    post_event(CMD_READ, pick_amount());
                    post_event(CMD_FRAME_TICK, pick_amount());
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        int p;
        ev_if.valid   <= 1'b0;
        ev_if.command <= CMD_READ;
        ev_if.amount  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_CRA_RATE;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        idle_on     = 1'b1;
        hold_wanted = 1'b0;
        phase_no    = -1;
        words_sent  = 0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words under the reset configuration: both maxima are
        // zero and the superframe is one frame long. Requests clamp to
        // zero, an oversized grant floors the volume request at zero and
        // a second grant saturates the allocated volume.
        post_event(CMD_READ, '1);
        post_event(CMD_VBDC_REQ, 16'd100);
        post_event(CMD_RBDC_REQ, 16'd50);
        post_event(CMD_FRAME_TICK, '0);
        post_event(CMD_VBDC_ALLOC, '1);
        post_event(CMD_VBDC_ALLOC, 16'd1);
        post_event(CMD_RBDC_ALLOC, '1);
        post_event(CMD_FCA_ALLOC, '1);
        post_event(CMD_READ, '0);
        wait_drained();

        // Top of every range, a two-frame timeout and a zero superframe
        // length, which must act as one frame.
        program_regs('1, '1, 16'd2, '1, 16'd0);
        post_event(CMD_RBDC_REQ, '1);
        post_event(CMD_ADD_CREDIT, '1);
        post_event(CMD_ADD_CREDIT, '1);
        // The timer is still running and credit is there, but the request
        // is already at its ceiling and must stay there.
        post_event(CMD_FRAME_TICK, '0);
        post_event(CMD_RBDC_ALLOC, '1);
        post_event(CMD_FCA_ALLOC, '1);
        // All three rate allocations at their maximum give the largest sum.
        post_event(CMD_READ, '1);
        post_event(CMD_VBDC_REQ, '1);
        post_event(CMD_VBDC_REQ, 16'd1);
        post_event(CMD_VBDC_ALLOC, 16'd2);
        // The timer runs out: request and credit are cleared.
        post_event(CMD_FRAME_TICK, '1);
        post_event(CMD_READ, '0);
        wait_drained();

        // Random phases, each under its own configuration. The last one
        // runs with no idling on either side.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    program_regs('1, '1, 16'h00FF, '1, 16'h00FF);
                end
                1:
                begin
                    program_regs('0, '0, '0, '0, 16'd1);
                end
                2:
                begin
                    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(1, 6)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(2, 16)));
                end
                3:
                begin
                    // Full-width data on the byte-wide registers as well;
                    // only the low byte counts.
                    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)));
                end
                4:
                begin
                    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 10)), 16'($urandom_range(0, 4000)),
                                 16'($urandom_range(1, 255)));
                end
                default:
                begin
                    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(1, 12)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(1, 8)));
                end
            endcase
            phase_no    = p;
            hold_wanted = (p == 0 || p == 3);
            idle_on     = (p != RANDOM_PHASES - 1);
            run_sessions(PHASE_WORDS, p != RANDOM_PHASES - 1);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && status_pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
